### rtl/core/scfd_pkg.sv
// Shared constants and result type for the switch command frame decoder.
package scfd_pkg;

  localparam int FLAG_W = 9;
  localparam int TIME_W = 16;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 2;

  localparam logic [BYTE_W-1:0] CH_ORDER_OPEN  = 8'h61;
  localparam logic [BYTE_W-1:0] CH_ORDER_CLOSE = 8'h62;
  localparam logic [BYTE_W-1:0] CH_TIME_OPEN   = 8'h63;
  localparam logic [BYTE_W-1:0] CH_TIME_CLOSE  = 8'h64;
  localparam logic [BYTE_W-1:0] CH_LINK        = 8'h67;
  localparam logic [BYTE_W-1:0] CH_ZERO        = 8'h30;
  localparam logic [BYTE_W-1:0] CH_ONE         = 8'h31;
  localparam logic [BYTE_W-1:0] CH_FOUR        = 8'h34;
  localparam logic [BYTE_W-1:0] CH_FIVE        = 8'h35;
  localparam logic [BYTE_W-1:0] CH_NINE        = 8'h39;

  localparam logic [IDX_W-1:0] IDX_FULL = 2'd3;
  localparam logic [IDX_W-1:0] IDX_ONE  = 2'd1;
  localparam logic [IDX_W-1:0] IDX_TWO  = 2'd2;
  localparam logic [3:0]       SEL_BEEP_MAX = 4'd5;

  typedef struct packed {
    logic [FLAG_W-1:0] switch_flags;
    logic [TIME_W-1:0] time_value;
    logic              time_updated;
    logic              buzzer_event;
    logic              link_event;
    logic              warn_clear;
  } res_t;

endpackage

### rtl/core/switch_command_frame_decoder.sv
// Top level of the switch command frame decoder.
// Each result is registered in the output buffer once its byte is accepted.
// Throughput: one byte per cycle; a one-entry skid register keeps in_ready
// high for one stalled result, so in_ready drops only when two results wait.
// Reset: synchronous active-low rst_n closes both frames, clears the capture
// buffer, capture index, appliance flags and time value, and drops pending results.
module switch_command_frame_decoder import scfd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [FLAG_W-1:0] out_switch_flags,
  output logic [TIME_W-1:0] out_time_value,
  output logic              out_time_updated,
  output logic              out_buzzer_event,
  output logic              out_link_event,
  output logic              out_warn_clear
);

  logic accept;
  res_t dec_res;
  res_t out_res;

  assign accept = in_valid && in_ready;

  scfd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .res     (dec_res)
  );

  scfd_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (dec_res),
    .push_ready (in_ready),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (out_res)
  );

  assign out_switch_flags = out_res.switch_flags;
  assign out_time_value   = out_res.time_value;
  assign out_time_updated = out_res.time_updated;
  assign out_buzzer_event = out_res.buzzer_event;
  assign out_link_event   = out_res.link_event;
  assign out_warn_clear   = out_res.warn_clear;

endmodule

### rtl/core/scfd_decode.sv
// Frame state registers and single-pass decode of one received byte.
module scfd_decode import scfd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] rx_byte,
  output res_t              res
);

  logic              order_open_r, order_open_nxt;
  logic              time_open_r, time_open_nxt;
  logic [BYTE_W-1:0] buf1_r, buf1_nxt;
  logic [BYTE_W-1:0] buf2_r, buf2_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [FLAG_W-1:0] flags_r, flags_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;

  logic              pair_ok;
  logic [BYTE_W-1:0] sel_full;
  logic [3:0]        sel;
  logic [FLAG_W-1:0] mask;
  logic [IDX_W-1:0]  idx_mid;
  logic [TIME_W-1:0] t1;
  logic [TIME_W-1:0] t2;

  always_comb begin
    order_open_nxt = order_open_r;
    time_open_nxt  = time_open_r;
    buf1_nxt       = buf1_r;
    buf2_nxt       = buf2_r;
    idx_nxt        = idx_r;
    flags_nxt      = flags_r;
    time_nxt       = time_r;
    idx_mid        = idx_r;
    res.time_updated = 1'b0;
    res.buzzer_event = 1'b0;
    res.link_event   = 1'b0;
    res.warn_clear   = 1'b0;

    pair_ok  = (buf1_r >= CH_ONE) && (buf1_r <= CH_NINE) &&
               ((buf2_r == CH_ZERO) || (buf2_r == CH_ONE));
    sel_full = buf1_r - CH_ONE;
    sel      = sel_full[3:0];
    mask     = {{(FLAG_W-1){1'b0}}, 1'b1} << sel;
    t1       = {{(TIME_W-BYTE_W){1'b0}}, buf1_r} - {{(TIME_W-BYTE_W){1'b0}}, CH_ZERO};
    t2       = (t1 << 3) + (t1 << 1) + {{(TIME_W-BYTE_W){1'b0}}, buf2_r}
               - {{(TIME_W-BYTE_W){1'b0}}, CH_ZERO};

    case (rx_byte)
      CH_ORDER_OPEN:  order_open_nxt = 1'b1;
      CH_ORDER_CLOSE: order_open_nxt = 1'b0;
      CH_TIME_OPEN:   time_open_nxt  = 1'b1;
      CH_TIME_CLOSE:  time_open_nxt  = 1'b0;
      CH_LINK:        res.link_event = 1'b1;
      default: ;
    endcase

    if (order_open_nxt || time_open_nxt) begin
      if (idx_r != IDX_FULL) begin
        if (idx_r == IDX_ONE) buf1_nxt = rx_byte;
        if (idx_r == IDX_TWO) buf2_nxt = rx_byte;
        idx_nxt = idx_r + 2'd1;
      end
    end else if (rx_byte == CH_ORDER_CLOSE) begin
      if (pair_ok) begin
        if (buf2_r == CH_ONE) flags_nxt = flags_r | mask;
        else flags_nxt = flags_r & ~mask;
        if (sel <= SEL_BEEP_MAX) idx_mid = IDX_ONE;
        if ((sel == 4'd0) && (buf2_r == CH_ZERO)) begin
          res.buzzer_event = 1'b1;
          res.link_event   = 1'b1;
        end
      end else if ((buf1_r == CH_FIVE) && (buf2_r == CH_FOUR)) begin
        res.warn_clear = 1'b1;
      end
      if ((idx_mid == IDX_ONE) && flags_nxt[0]) res.buzzer_event = 1'b1;
      idx_nxt = '0;
    end else if (rx_byte == CH_TIME_CLOSE) begin
      time_nxt = t2;
      res.time_updated = 1'b1;
      idx_nxt = '0;
    end

    res.switch_flags = flags_nxt;
    res.time_value   = time_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_open_r <= 1'b0;
      time_open_r  <= 1'b0;
      buf1_r       <= '0;
      buf2_r       <= '0;
      idx_r        <= '0;
      flags_r      <= '0;
      time_r       <= '0;
    end else if (accept) begin
      order_open_r <= order_open_nxt;
      time_open_r  <= time_open_nxt;
      buf1_r       <= buf1_nxt;
      buf2_r       <= buf2_nxt;
      idx_r        <= idx_nxt;
      flags_r      <= flags_nxt;
      time_r       <= time_nxt;
    end
  end

`ifndef SYNTHESIS
  a_time_alone: assert property (@(posedge clk) disable iff (!rst_n)
    accept && res.time_updated |-> !res.buzzer_event && !res.warn_clear)
    else $error("time close raised a switch event");

  a_warn_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
    accept && res.warn_clear |=> flags_r == $past(flags_r))
    else $error("warning clear changed appliance flags");
`endif

endmodule

### rtl/core/scfd_out_buf.sv
// Result register with one skid entry between decode and the result channel.
module scfd_out_buf import scfd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic push_ready,
  output logic pop_valid,
  input  logic pop_ready,
  output res_t pop_data
);

  logic main_valid_r;
  logic skid_valid_r;
  res_t main_r;
  res_t skid_r;
  logic pop;

  assign pop        = main_valid_r && pop_ready;
  assign push_ready = !skid_valid_r;
  assign pop_valid  = main_valid_r;
  assign pop_data   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (main_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        main_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) main_r <= skid_r;
    end else if (push) begin
      if (main_valid_r && !pop) skid_r <= push_data;
      else main_r <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held without main entry");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push && !main_valid_r |=> main_valid_r && !skid_valid_r)
    else $error("beat into empty buffer not in main entry");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    push && main_valid_r && !pop |=> skid_valid_r)
    else $error("stalled beat not held in skid entry");
`endif

endmodule
